// ===== hw/rtl/ptpf_pkg.sv =====
// Package: shared types, character codes and helpers for the path traversal filter.
`timescale 1ns / 1ps

package ptpf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned WinDepth = 4;

  // Configuration register indexes
  localparam logic CFG_CONFIGURED     = 1'b0;
  localparam logic CFG_ALLOW_ABSOLUTE = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_C   = 8'h63;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;

  typedef enum logic [StatusW-1:0] {
    ST_SAFE         = 3'd0,
    ST_UNCONFIGURED = 3'd1,
    ST_ZERO_BYTE    = 3'd2,
    ST_TRAVERSAL    = 3'd3,
    ST_ENCODED      = 3'd4,
    ST_ABSOLUTE     = 3'd5
  } status_t;

  // Sticky per-path findings, as they stand after the current byte
  typedef struct packed {
    logic zero_byte;
    logic traversal;
    logic encoded;
    logic absolute;
  } flags_t;

  function automatic logic [7:0] fold_case(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    if (x >= CH_UP_A && x <= CH_UP_Z) begin
      r = x | 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] x);
    logic [7:0] f;
    f = fold_case(x);
    return (f >= CH_LO_A) && (f <= CH_LO_Z);
  endfunction

endpackage

// ===== hw/rtl/path_traversal_pattern_filter_unit.sv =====
// Top level: path traversal pattern filter, one path byte per request.
// The status is registered and appears in the cycle after the last byte is accepted.
// Throughput: one byte per cycle unless stalled; the scanner and status logic sit between the
//   window/flag registers and the output register, which holds one status.
// Input stalls only while a status is held and the output side is not ready.
// Reset (rst, synchronous, active high) clears the window, the flags, both
//   configuration bits and the output valid.
`timescale 1ns / 1ps

module path_traversal_pattern_filter_unit (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] path_byte
  input  logic       s_tlast,   // last_byte
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] status, [7:3] zero
  // configuration writes
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  logic             configured;
  logic             allow_absolute;
  logic             in_accept;
  ptpf_pkg::flags_t flags_next;
  logic [ptpf_pkg::StatusW-1:0] status;

  // Output register frees a slot whenever it is empty or being drained.
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  // Config registers; sampled when the last byte of a path is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      configured     <= 1'b0;
      allow_absolute <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptpf_pkg::CFG_CONFIGURED:     configured     <= cfg_data;
        ptpf_pkg::CFG_ALLOW_ABSOLUTE: allow_absolute <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window of the last four bytes and the sticky findings for this path.
  ptpf_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .path_byte  (s_tdata),
    .last_byte  (s_tlast),
    .flags_next (flags_next)
  );

  // Status picked by priority at the last byte and held until taken.
  ptpf_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (in_accept && s_tlast),
    .flags          (flags_next),
    .configured     (configured),
    .allow_absolute (allow_absolute),
    .take           (m_tready),
    .busy           (m_tvalid),
    .status         (status)
  );

  assign m_tdata = {{(8 - ptpf_pkg::StatusW){1'b0}}, status};

endmodule

// ===== hw/rtl/ptpf_scan.sv =====
// Byte scanner: sliding window, pattern matches and sticky per-path flags.
`timescale 1ns / 1ps

module ptpf_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            path_byte,
  input  logic                  last_byte,
  output ptpf_pkg::flags_t      flags_next
);

  logic [7:0]       recent [ptpf_pkg::WinDepth];
  logic [1:0]       pct_e_count;
  logic [1:0]       pct_e_count_next;
  logic [1:0]       byte_pos;
  ptpf_pkg::flags_t flags;

  logic [7:0] fc;
  logic       pct2;
  logic       dot_hit;
  logic       enc_hit;
  logic       abs_hit;
  logic       trav_hit;

  always_comb begin
    fc      = ptpf_pkg::fold_case(path_byte);
    pct2    = (recent[1] == ptpf_pkg::CH_PCT) && (recent[0] == ptpf_pkg::CH_TWO);
    dot_hit = pct2 && (fc == ptpf_pkg::CH_LO_E);

    pct_e_count_next = pct_e_count;
    if (dot_hit && pct_e_count != 2'd2) begin
      pct_e_count_next = pct_e_count + 2'd1;
    end

    trav_hit = ((recent[0] == ptpf_pkg::CH_DOT) && (path_byte == ptpf_pkg::CH_DOT)) ||
               ((recent[0] == ptpf_pkg::CH_TILDE) && (path_byte == ptpf_pkg::CH_SLASH));

    enc_hit = (pct2 && fc == ptpf_pkg::CH_LO_F) ||
              ((recent[1] == ptpf_pkg::CH_PCT) && (recent[0] == ptpf_pkg::CH_FIVE) &&
               (fc == ptpf_pkg::CH_LO_C)) ||
              ((recent[3] == ptpf_pkg::CH_PCT) && (recent[2] == ptpf_pkg::CH_TWO) &&
               (recent[1] == ptpf_pkg::CH_FIVE) && (recent[0] == ptpf_pkg::CH_TWO) &&
               (fc == ptpf_pkg::CH_LO_E || fc == ptpf_pkg::CH_LO_F)) ||
              (dot_hit && pct_e_count_next == 2'd2);

    abs_hit = ((byte_pos == 2'd0) &&
               (path_byte == ptpf_pkg::CH_SLASH || path_byte == ptpf_pkg::CH_BSLASH)) ||
              ((byte_pos == 2'd1) && (path_byte == ptpf_pkg::CH_COLON) &&
               ptpf_pkg::is_letter(recent[0]));

    flags_next.zero_byte = flags.zero_byte | (path_byte == ptpf_pkg::CH_NUL);
    flags_next.traversal = flags.traversal | trav_hit;
    flags_next.encoded   = flags.encoded   | enc_hit;
    flags_next.absolute  = flags.absolute  | abs_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptpf_pkg::WinDepth; i++) begin
        recent[i] <= '0;
      end
      pct_e_count <= '0;
      byte_pos    <= '0;
      flags       <= '0;
    end else if (accept) begin
      if (last_byte) begin
        // path done: start the next one clean
        for (int i = 0; i < ptpf_pkg::WinDepth; i++) begin
          recent[i] <= '0;
        end
        pct_e_count <= '0;
        byte_pos    <= '0;
        flags       <= '0;
      end else begin
        for (int i = ptpf_pkg::WinDepth - 1; i > 0; i--) begin
          recent[i] <= recent[i-1];
        end
        recent[0]   <= path_byte;
        pct_e_count <= pct_e_count_next;
        if (byte_pos != 2'd2) begin
          byte_pos <= byte_pos + 2'd1;
        end
        flags <= flags_next;
      end
    end
  end

endmodule

// ===== hw/rtl/ptpf_out.sv =====
// Status priority encode and output register with stream handshake.
`timescale 1ns / 1ps

module ptpf_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  ptpf_pkg::flags_t              flags,
  input  logic                          configured,
  input  logic                          allow_absolute,
  input  logic                          take,
  output logic                          busy,
  output logic [ptpf_pkg::StatusW-1:0]  status
);

  ptpf_pkg::status_t status_next;

  always_comb begin
    if (!configured) begin
      status_next = ptpf_pkg::ST_UNCONFIGURED;
    end else if (flags.zero_byte) begin
      status_next = ptpf_pkg::ST_ZERO_BYTE;
    end else if (flags.traversal) begin
      status_next = ptpf_pkg::ST_TRAVERSAL;
    end else if (flags.encoded) begin
      status_next = ptpf_pkg::ST_ENCODED;
    end else if (!allow_absolute && flags.absolute) begin
      status_next = ptpf_pkg::ST_ABSOLUTE;
    end else begin
      status_next = ptpf_pkg::ST_SAFE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (take) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
    end
  end

endmodule

// ===== hw/rtl/ptpf_checker.sv =====
// Port-level checker for the path traversal filter, bound to the top level.
`timescale 1ns / 1ps

module ptpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A held status does not change while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("status changed while stalled");

  // Only defined status codes leave the block.
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:3] == 5'd0 && m_tdata[2:0] <= 3'd5)
    else $error("undefined status code");

  // The last byte of a path always yields a status next cycle.
  a_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("missing status after last byte");

  // Input only backs up behind a full, stalled output.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without cause");

  // A status appears only after a last byte or is still held.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("status without a completed path");

endmodule

bind path_traversal_pattern_filter_unit ptpf_checker u_ptpf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/path_traversal_pattern_filter_unit_tb.sv =====
// Self-checking testbench for the path traversal filter: byte stimulus, status scoreboard.
`timescale 1ns / 1ps

module path_traversal_pattern_filter_unit_tb;

  localparam int unsigned StallLimit = 2000;  // cycles with no request moving anywhere
  localparam int unsigned HoldCycles = 80;    // long receiver back-off
  localparam int unsigned IdlePct    = 30;
  localparam int unsigned ShowMax    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } path_req_t;

  // DUT ports; the inputs driven here are known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;    // [7:0] path_byte
  logic       s_tlast = 1'b0;     // last_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [2:0] status, [7:3] zero
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;

  path_traversal_pattern_filter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Byte requests waiting for the driver, and statuses owed by the DUT
  path_req_t           path_bytes_q[$];
  ptpf_pkg::status_t   due_status[$];
  logic [7:0]          path_buf[$];        // path under construction

  // Shadow copy of the filter: configuration plus per-path scan state
  logic       cfg_on = 1'b0;
  logic       abs_ok = 1'b0;
  logic [7:0] win [0:3];          // newest byte in win[0]
  logic [1:0] enc_dots;
  logic [1:0] pos;
  logic       saw_zero, saw_trav, saw_enc, saw_abs;

  // Traffic shaping shared with the driver processes
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  bit         stall_phase = 1'b0;
  bit         in_taken = 1'b0;    // request accepted at the last rising edge

  int unsigned       errors = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       hold_left = 0;
  bit                hold_done = 1'b0;
  path_req_t         next_req;
  ptpf_pkg::status_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow filter
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= ptpf_pkg::CH_UP_A && c <= ptpf_pkg::CH_UP_Z) return c + 8'd32;
    return c;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= ptpf_pkg::CH_UP_A && c <= ptpf_pkg::CH_UP_Z) ||
           (c >= ptpf_pkg::CH_LO_A && c <= ptpf_pkg::CH_LO_Z);
  endfunction

  function automatic void clear_scan();
    for (int i = 0; i < 4; i++) win[i] = 8'h00;
    enc_dots = 2'd0;
    pos      = 2'd0;
    saw_zero = 1'b0;
    saw_trav = 1'b0;
    saw_enc  = 1'b0;
    saw_abs  = 1'b0;
  endfunction

  // Advance the shadow state by one accepted byte; the last byte owes a status
  function automatic void scan_byte(input logic [7:0] c, input logic last);
    logic [7:0]        lc;
    logic              pct2;
    ptpf_pkg::status_t st;
    lc   = to_lower(c);
    pct2 = (win[1] == ptpf_pkg::CH_PCT) && (win[0] == ptpf_pkg::CH_TWO);
    if (c == ptpf_pkg::CH_NUL) saw_zero = 1'b1;
    if ((win[0] == ptpf_pkg::CH_DOT && c == ptpf_pkg::CH_DOT) ||
        (win[0] == ptpf_pkg::CH_TILDE && c == ptpf_pkg::CH_SLASH))
      saw_trav = 1'b1;
    if (pct2 && lc == ptpf_pkg::CH_LO_F) saw_enc = 1'b1;
    if (win[1] == ptpf_pkg::CH_PCT && win[0] == ptpf_pkg::CH_FIVE &&
        lc == ptpf_pkg::CH_LO_C)
      saw_enc = 1'b1;
    // double-encoded %252e / %252f
    if (win[3] == ptpf_pkg::CH_PCT && win[2] == ptpf_pkg::CH_TWO &&
        win[1] == ptpf_pkg::CH_FIVE && win[0] == ptpf_pkg::CH_TWO &&
        (lc == ptpf_pkg::CH_LO_E || lc == ptpf_pkg::CH_LO_F))
      saw_enc = 1'b1;
    // encoded dots only count as encoded from the second one on
    if (pct2 && lc == ptpf_pkg::CH_LO_E) begin
      if (enc_dots < 2'd2) enc_dots = enc_dots + 2'd1;
      if (enc_dots >= 2'd2) saw_enc = 1'b1;
    end
    // absolute: leading separator, or letter then colon
    if (pos == 2'd0 && (c == ptpf_pkg::CH_SLASH || c == ptpf_pkg::CH_BSLASH))
      saw_abs = 1'b1;
    if (pos == 2'd1 && c == ptpf_pkg::CH_COLON && is_alpha(win[0])) saw_abs = 1'b1;
    if (pos < 2'd2) pos = pos + 2'd1;
    win[3] = win[2];
    win[2] = win[1];
    win[1] = win[0];
    win[0] = c;
    if (last) begin
      // registers are sampled at the last byte
      if (!cfg_on)                 st = ptpf_pkg::ST_UNCONFIGURED;
      else if (saw_zero)           st = ptpf_pkg::ST_ZERO_BYTE;
      else if (saw_trav)           st = ptpf_pkg::ST_TRAVERSAL;
      else if (saw_enc)            st = ptpf_pkg::ST_ENCODED;
      else if (!abs_ok && saw_abs) st = ptpf_pkg::ST_ABSOLUTE;
      else                         st = ptpf_pkg::ST_SAFE;
      due_status.push_back(st);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: input acceptance, status check, watchdog (all at the rising edge)
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_taken     = 1'b0;
      quiet_cycles = 0;
      clear_scan();
    end else begin
      in_taken = s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (due_status.size() == 0) begin
          errors++;
          if (errors <= ShowMax)
            $display("unexpected status %0d, no path outstanding", m_tdata[2:0]);
        end else begin
          want = due_status.pop_front();
          if (m_tdata[2:0] !== want || m_tdata[7:3] !== 5'd0) begin
            errors++;
            if (errors <= ShowMax)
              $display("status mismatch: expected %0d (%s), got %0d, tdata %h",
                       want, want.name(), m_tdata[2:0], m_tdata);
          end
        end
      end
      if (in_taken) scan_byte(s_tdata, s_tlast);
      if (in_taken || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one request per falling edge from the byte queue while the DUT accepts, random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (path_bytes_q.size() != 0 && (tx_calm || $urandom_range(0, 99) >= IdlePct)) begin
        next_req = path_bytes_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_req.data;
        s_tlast  <= next_req.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold in the stall phase so
  // the status register fills and the input side stalls
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_phase && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= rx_calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // Path construction
  // ---------------------------------------------------------------------------
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endtask

  // Hand the path under construction to the sender, tlast on its final byte
  task automatic flush_path();
    path_req_t r;
    for (int i = 0; i < path_buf.size(); i++) begin
      r.data = path_buf[i];
      r.last = (i == path_buf.size() - 1);
      path_bytes_q.push_back(r);
    end
    path_buf.delete();
  endtask

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= ptpf_pkg::CH_LO_A && c <= ptpf_pkg::CH_LO_Z && $urandom_range(0, 1) == 1)
      return c - 8'd32;
    return c;
  endfunction

  // Harmless path characters; '/' only past the first byte
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 5))
      0, 1:    return mix_case(ptpf_pkg::CH_LO_A + 8'($urandom_range(0, 25)));
      2:       return 8'h30 + 8'($urandom_range(0, 9));
      3:       return 8'h5f;  // underscore
      4:       return 8'h2d;  // dash
      default: return (path_buf.size() == 0) ? 8'h2d : ptpf_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdef";
    return mix_case(digits[$urandom_range(0, 15)]);
  endfunction

  // Token that trips (or nearly trips) one of the detectors
  task automatic put_hazard();
    case ($urandom_range(0, 11))
      0: put_text("..");
      1: put_text("~/");
      2: begin put_text("%2"); path_buf.push_back(mix_case(ptpf_pkg::CH_LO_F)); end
      3: begin put_text("%5"); path_buf.push_back(mix_case(ptpf_pkg::CH_LO_C)); end
      4: begin
        put_text("%252");
        path_buf.push_back(mix_case($urandom_range(0, 1) ? ptpf_pkg::CH_LO_E
                                                           : ptpf_pkg::CH_LO_F));
      end
      5, 6: begin put_text("%2"); path_buf.push_back(mix_case(ptpf_pkg::CH_LO_E)); end
      7: path_buf.push_back(ptpf_pkg::CH_NUL);
      8: begin path_buf.push_back(ptpf_pkg::CH_PCT); path_buf.push_back(hex_char());
        path_buf.push_back(hex_char()); end
      9: path_buf.push_back(8'($urandom_range(0, 255)));
      10: path_buf.push_back(ptpf_pkg::CH_DOT);
      default: path_buf.push_back(ptpf_pkg::CH_TILDE);
    endcase
  endtask

  task automatic random_path();
    int n;
    path_buf.delete();
    if ($urandom_range(0, 7) == 0) begin
      // noise: raw bytes of any value
      n = $urandom_range(1, 8);
      repeat (n) path_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0: path_buf.push_back(ptpf_pkg::CH_SLASH);
        1: path_buf.push_back(ptpf_pkg::CH_BSLASH);
        2: begin
          path_buf.push_back(mix_case(ptpf_pkg::CH_LO_A + 8'($urandom_range(0, 25))));
          if ($urandom_range(0, 3) != 0) path_buf.push_back(ptpf_pkg::CH_COLON);
        end
        default: ;
      endcase
      // mostly short paths, now and then a long one
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 48) : $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) put_hazard();
        else path_buf.push_back(filler_byte());
      end
      if (path_buf.size() == 0) path_buf.push_back(filler_byte());
    end
  endtask

  task automatic random_paths(input int budget);
    int used;
    used = 0;
    while (used < budget) begin
      random_path();
      used += path_buf.size();
      flush_path();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ptpf_pkg::CFG_CONFIGURED) cfg_on = val;
    else abs_ok = val;
  endtask

  // Wait until the sender has no more bytes and every owed status has come
  // back, then idle on for the output register
  task automatic drain();
    while (path_bytes_q.size() != 0 || s_tvalid || due_status.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic on, input logic abs);
    write_reg(ptpf_pkg::CFG_CONFIGURED, on);
    write_reg(ptpf_pkg::CFG_ALLOW_ABSOLUTE, abs);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: unconfigured single-byte path, then each detector at least once
    set_regs(1'b0, 1'b0);
    put_text("/");
    flush_path();
    drain();
    set_regs(1'b1, 1'b0);
    path_buf.push_back(ptpf_pkg::CH_NUL);
    flush_path();
    put_text("..");
    flush_path();
    put_text("~/");
    flush_path();
    put_text("%2F");
    flush_path();
    put_text("%5c");
    flush_path();
    put_text("%252e");
    flush_path();
    put_text("%2e%2E");
    flush_path();
    put_text("A:");
    flush_path();
    drain();

    // Random phases across register settings
    random_paths(250);
    drain();
    set_regs(1'b1, 1'b1);
    random_paths(250);
    drain();
    set_regs(1'b0, 1'b1);
    random_paths(150);
    drain();

    // Back-pressure phase: sender streams while the receiver holds off
    set_regs(1'b1, 1'b0);
    tx_calm     = 1'b1;
    stall_phase = 1'b1;
    random_paths(250);
    drain();
    stall_phase = 1'b0;

    // Full-rate stretch, no idling on either side
    set_regs(1'b1, 1'b1);
    rx_calm = 1'b1;
    random_paths(300);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
